// File: rtl/cartridge_bank_controller_assert.svh
// assertion macros for the cartridge bank controller
// used by files that check their own pipeline; expects clk and rst_n in scope
`ifndef CARTRIDGE_BANK_CONTROLLER_ASSERT_SVH
`define CARTRIDGE_BANK_CONTROLLER_ASSERT_SVH

// condition implies consequence in the same cycle
`define CBC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define CBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cbc_pkg.sv
// shared types and constants for the cartridge bank controller
// no dependencies; used by every rtl module of the block
`timescale 1ns / 1ps

package cbc_pkg;

    // external ram geometry, always a power of two
    localparam int RAM_AW    = 17;
    localparam int RAM_BYTES = 1 << RAM_AW;
    // width of a full bank plus offset index
    localparam int IDX_W     = 17;

    // controller kinds
    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_MBC1  = 3'd1;
    localparam logic [2:0] KIND_MBC2  = 3'd2;
    localparam logic [2:0] KIND_MBC3  = 3'd3;
    localparam logic [2:0] KIND_MBC5  = 3'd4;
    localparam logic [2:0] KIND_MULTI = 3'd5;

    // request types
    localparam logic [1:0] REQ_REG   = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // config register indexes
    localparam logic [2:0] CFG_KIND        = 3'd0;
    localparam logic [2:0] CFG_ROM_MASK    = 3'd1;
    localparam logic [2:0] CFG_RAM_MASK    = 3'd2;
    localparam logic [2:0] CFG_OFFSET_MASK = 3'd3;
    localparam logic [2:0] CFG_RAM_PRESENT = 3'd4;
    localparam logic [2:0] CFG_ROM_BANKING = 3'd5;
    localparam logic [2:0] CFG_UNBANKED    = 3'd6;

    // register write regions, address bits 14:13
    localparam logic [1:0] REGION_ENABLE = 2'd0;
    localparam logic [1:0] REGION_ROM    = 2'd1;
    localparam logic [1:0] REGION_RAM    = 2'd2;
    localparam logic [1:0] REGION_MODE   = 2'd3;

    localparam logic [3:0] ENABLE_KEY = 4'hA;
    localparam logic [7:0] MBC2_HIGH  = 8'hF0;
    localparam logic [7:0] NO_DATA    = 8'hFF;

    typedef struct packed {
        logic [2:0]  kind;
        logic [8:0]  rom_bank_mask;
        logic [3:0]  ram_bank_mask;
        logic [12:0] ram_offset_mask;
        logic        ram_present;
        logic        rom_banking_on;
        logic        ram_unbanked;
    } cbc_cfg_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] addr;
        logic [7:0]  data;
    } cbc_req_t;

    typedef struct packed {
        logic [3:0] ram_bank;
        logic       ram_enable;
    } cbc_ram_state_t;

    typedef struct packed {
        logic [6:0] rom_lower;
        logic [8:0] rom_upper;
        logic [3:0] ram_bank;
        logic       ram_en;
    } cbc_view_t;

endpackage

// File: rtl/cbc_mapper.sv
// banking register file and register write decode for all controller kinds
// depends on cbc_pkg
`timescale 1ns / 1ps

module cbc_mapper (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cbc_pkg::cbc_cfg_t       cfg,
    input  cbc_pkg::cbc_req_t       req,
    input  logic                    commit,
    output cbc_pkg::cbc_ram_state_t ram_state,
    output cbc_pkg::cbc_view_t      view
);

    logic [8:0] rom_bank_reg, rom_bank_next;
    logic [3:0] ram_bank_reg, ram_bank_next;
    logic       ram_enable_reg, ram_enable_next;
    logic       mode_reg, mode_next;
    logic [5:0] outer_bank_reg, outer_bank_next;
    logic [5:0] inner_bank_reg, inner_bank_next;
    logic [5:0] outer_mask_reg, outer_mask_next;
    logic [5:0] inner_mask_reg, inner_mask_next;
    logic       phase_reg, phase_next;
    logic       locked_reg, locked_next;

    logic [8:0] b9;
    logic [6:0] b7;
    logic [1:0] region;
    logic       reg_wr;
    logic       multi;
    logic [5:0] outer_sel;
    logic [6:0] base_bank;
    logic [6:0] switch_bank;

    // register write decode
    always_comb
    begin
        rom_bank_next   = rom_bank_reg;
        ram_bank_next   = ram_bank_reg;
        ram_enable_next = ram_enable_reg;
        mode_next       = mode_reg;
        outer_bank_next = outer_bank_reg;
        inner_bank_next = inner_bank_reg;
        outer_mask_next = outer_mask_reg;
        inner_mask_next = inner_mask_reg;
        phase_next      = phase_reg;
        locked_next     = locked_reg;
        b9     = '0;
        b7     = req.data[6:0];
        region = req.addr[14:13];
        reg_wr = (req.req_type == cbc_pkg::REQ_REG) && !req.addr[15];

        // seven-bit rom bank of mbc2 and mbc3, zero selects bank one
        if (b7 == 7'd0)
        begin
            b7 = 7'd1;
        end

        if (reg_wr)
        begin
            unique case (cfg.kind)
                cbc_pkg::KIND_MBC1:
                begin
                    unique case (region)
                        cbc_pkg::REGION_ENABLE:
                        begin
                            ram_enable_next = (req.data[3:0] == cbc_pkg::ENABLE_KEY);
                        end
                        cbc_pkg::REGION_ROM:
                        begin
                            if (cfg.rom_banking_on)
                            begin
                                b9 = {rom_bank_reg[8:5], req.data[4:0]};
                                if (b9[4:0] == 5'd0)
                                begin
                                    b9[0] = 1'b1;
                                end
                                rom_bank_next = b9 & cfg.rom_bank_mask;
                            end
                        end
                        cbc_pkg::REGION_RAM:
                        begin
                            if (mode_reg)
                            begin
                                if (cfg.ram_present)
                                begin
                                    ram_bank_next = {2'b00, req.data[1:0]} & cfg.ram_bank_mask;
                                end
                            end
                            else if (cfg.rom_banking_on)
                            begin
                                b9 = {2'b00, req.data[1:0], rom_bank_reg[4:0]};
                                if (b9[4:0] == 5'd0)
                                begin
                                    b9[0] = 1'b1;
                                end
                                rom_bank_next = b9 & cfg.rom_bank_mask;
                            end
                        end
                        cbc_pkg::REGION_MODE:
                        begin
                            mode_next = (req.data != 8'd0);
                        end
                        default: ;
                    endcase
                end
                cbc_pkg::KIND_MBC2:
                begin
                    if (region == cbc_pkg::REGION_ENABLE && !req.addr[8])
                    begin
                        ram_enable_next = (req.data[3:0] == cbc_pkg::ENABLE_KEY);
                    end
                    else if (region == cbc_pkg::REGION_ROM && req.addr[8]
                             && cfg.rom_banking_on)
                    begin
                        rom_bank_next = {2'b00, b7} & cfg.rom_bank_mask;
                    end
                end
                cbc_pkg::KIND_MBC3:
                begin
                    unique case (region)
                        cbc_pkg::REGION_ENABLE:
                        begin
                            ram_enable_next = (req.data[3:0] == cbc_pkg::ENABLE_KEY);
                        end
                        cbc_pkg::REGION_ROM:
                        begin
                            if (cfg.rom_banking_on)
                            begin
                                rom_bank_next = {2'b00, b7} & cfg.rom_bank_mask;
                            end
                        end
                        cbc_pkg::REGION_RAM:
                        begin
                            // clock register selects are ignored
                            if (req.data[3:2] == 2'b00 && cfg.ram_present)
                            begin
                                ram_bank_next = {2'b00, req.data[1:0]} & cfg.ram_bank_mask;
                            end
                        end
                        default: ;
                    endcase
                end
                cbc_pkg::KIND_MBC5:
                begin
                    unique case (region)
                        cbc_pkg::REGION_ENABLE:
                        begin
                            ram_enable_next = (req.data[3:0] == cbc_pkg::ENABLE_KEY);
                        end
                        cbc_pkg::REGION_ROM:
                        begin
                            if (cfg.rom_banking_on)
                            begin
                                // low half sets bits 7:0, high half sets bit 8
                                if (req.addr[12])
                                begin
                                    rom_bank_next = {req.data[0], rom_bank_reg[7:0]}
                                                    & cfg.rom_bank_mask;
                                end
                                else
                                begin
                                    rom_bank_next = {rom_bank_reg[8], req.data}
                                                    & cfg.rom_bank_mask;
                                end
                            end
                        end
                        cbc_pkg::REGION_RAM:
                        begin
                            if (cfg.ram_present)
                            begin
                                ram_bank_next = req.data[3:0] & cfg.ram_bank_mask;
                            end
                        end
                        default: ;
                    endcase
                end
                cbc_pkg::KIND_MULTI:
                begin
                    if (region == cbc_pkg::REGION_ROM)
                    begin
                        inner_bank_next = (req.data[5:0] == 6'd0) ? 6'd1 : req.data[5:0];
                    end
                    else if (region == cbc_pkg::REGION_MODE && !locked_reg)
                    begin
                        // two-phase outer bank then mask and lock write
                        if (!phase_reg)
                        begin
                            outer_bank_next = req.data[5:0];
                        end
                        else
                        begin
                            inner_mask_next = ~{req.data[4:0], 1'b0};
                            outer_mask_next = {1'b1, req.data[4:0]};
                            locked_next     = req.data[5];
                        end
                        phase_next = !phase_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // multicart base and switched banks, seven-bit wrap
    always_comb
    begin
        multi       = (cfg.kind == cbc_pkg::KIND_MULTI);
        outer_sel   = outer_bank_next & outer_mask_next;
        base_bank   = {outer_sel, 1'b0};
        switch_bank = base_bank + {1'b0, inner_bank_next & inner_mask_next};

        view.rom_lower = multi ? base_bank : 7'd0;
        view.rom_upper = multi ? {2'b00, switch_bank} : rom_bank_next;
        view.ram_bank  = ram_bank_next;
        view.ram_en    = cfg.ram_present
                         && ((cfg.ram_unbanked && cfg.kind != cbc_pkg::KIND_MBC2)
                             || ram_enable_next);

        ram_state.ram_bank   = ram_bank_reg;
        ram_state.ram_enable = ram_enable_reg;
    end

    // banking registers update when a request leaves the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_reg   <= 9'd1;
            ram_bank_reg   <= 4'd0;
            ram_enable_reg <= 1'b0;
            mode_reg       <= 1'b0;
            outer_bank_reg <= 6'd0;
            inner_bank_reg <= 6'd1;
            outer_mask_reg <= 6'h20;
            inner_mask_reg <= 6'h3F;
            phase_reg      <= 1'b0;
            locked_reg     <= 1'b0;
        end
        else if (commit)
        begin
            rom_bank_reg   <= rom_bank_next;
            ram_bank_reg   <= ram_bank_next;
            ram_enable_reg <= ram_enable_next;
            mode_reg       <= mode_next;
            outer_bank_reg <= outer_bank_next;
            inner_bank_reg <= inner_bank_next;
            outer_mask_reg <= outer_mask_next;
            inner_mask_reg <= inner_mask_next;
            phase_reg      <= phase_next;
            locked_reg     <= locked_next;
        end
    end

endmodule

// File: rtl/cbc_ram.sv
// external cartridge ram: address mapping, single-port array, reset clearing sweep
// depends on cbc_pkg
`timescale 1ns / 1ps

module cbc_ram (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cbc_pkg::cbc_cfg_t       cfg,
    input  cbc_pkg::cbc_req_t       req,
    input  cbc_pkg::cbc_ram_state_t ram_state,
    input  logic                    step,
    output logic [7:0]              read_data,
    output logic                    clr_busy
);

    logic [7:0] mem [cbc_pkg::RAM_BYTES];

    logic [cbc_pkg::IDX_W-1:0]  full_idx;
    logic [cbc_pkg::RAM_AW-1:0] item_addr;
    logic [cbc_pkg::RAM_AW-1:0] wr_addr;
    logic [12:0]                offset;
    logic                       is_mbc2;
    logic                       ungated;
    logic                       hit;
    logic                       item_wr;
    logic                       item_rd;
    logic                       wr_en;
    logic [7:0]                 wr_byte;
    logic [7:0]                 q_reg;
    logic                       use_q_reg;
    logic                       or_f0_reg;
    logic [cbc_pkg::RAM_AW-1:0] clr_addr_reg;
    logic                       clr_busy_reg;

    // address mapping and access gating
    always_comb
    begin
        is_mbc2 = (cfg.kind == cbc_pkg::KIND_MBC2);
        ungated = cfg.ram_unbanked && !is_mbc2;
        offset  = req.addr[12:0] & cfg.ram_offset_mask;
        hit     = cfg.ram_present && (ungated || ram_state.ram_enable);
        if (is_mbc2)
        begin
            full_idx = {{(cbc_pkg::IDX_W - 9){1'b0}}, req.addr[8:0]};
        end
        else if (ungated)
        begin
            full_idx = {4'd0, offset};
        end
        else
        begin
            full_idx = {ram_state.ram_bank, offset};
        end
        // index wraps at the array size
        item_addr = full_idx[cbc_pkg::RAM_AW-1:0];
        item_wr   = step && (req.req_type == cbc_pkg::REQ_WRITE) && hit;
        item_rd   = step && (req.req_type == cbc_pkg::REQ_READ) && hit;
    end

    // single write port shared by the clearing sweep and requests
    always_comb
    begin
        wr_en   = clr_busy_reg || item_wr;
        wr_addr = clr_busy_reg ? clr_addr_reg : item_addr;
        if (clr_busy_reg)
        begin
            wr_byte = 8'd0;
        end
        else if (is_mbc2)
        begin
            wr_byte = req.data | cbc_pkg::MBC2_HIGH;
        end
        else
        begin
            wr_byte = req.data;
        end
    end

    // array and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_byte;
        end
        if (item_rd)
        begin
            q_reg <= mem[item_addr];
        end
        if (step)
        begin
            use_q_reg <= (req.req_type == cbc_pkg::REQ_READ) && hit;
            or_f0_reg <= is_mbc2;
        end
    end

    // clearing sweep after reset, one byte per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == cbc_pkg::RAM_AW'(cbc_pkg::RAM_BYTES - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // mbc2 cells read with the upper nibble set
    assign read_data = use_q_reg ? (q_reg | (or_f0_reg ? cbc_pkg::MBC2_HIGH : 8'h00))
                                 : cbc_pkg::NO_DATA;
    assign clr_busy  = clr_busy_reg;

endmodule

// File: rtl/cartridge_bank_controller.sv
// top level of the cartridge bank controller: config registers, input and result stages
// depends on cbc_pkg, cbc_mapper, cbc_ram and cartridge_bank_controller_assert.svh
`timescale 1ns / 1ps
`include "cartridge_bank_controller_assert.svh"

// usage
//   s_axis carries one bus access request: register write, external ram read or write.
//   m_axis returns one result per request: read byte and the bank mapping after it.
//   cfg writes one configuration register by index; write it only while idle.
// pipeline and throughput
//   an accepted request is registered in the input stage, decoded against the banking
//   registers and the ram, and its result is registered in the result stage; while
//   m_axis_tready stays high, one request per cycle is sustained, set by the single ram port
//   and the single decode stage between the input and result registers.
// reset
//   banking and config registers take their reset values; then the 128 KiB ram
//   (RAM_BYTES, 131072 bytes) is zeroed one byte a cycle, with s_axis_tready low.
//   cfg writes are taken during the sweep.
// stalls
//   while m_axis_tready is low the result holds; one more request is still taken
//   into the input stage, after which s_axis_tready drops until the result leaves.

module cartridge_bank_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // bus_address[15:0], write_data[23:16]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // read_data[7:0], rom_bank_lower[14:8],
                                        // rom_bank_upper[23:15], ram_bank_now[27:24],
                                        // ram_enabled_now[28], zero[31:29]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    cbc_pkg::cbc_cfg_t       cfg_reg;
    cbc_pkg::cbc_req_t       req_reg;
    logic                    s1_valid_reg;
    logic                    out_valid_reg;
    cbc_pkg::cbc_view_t      view_reg;
    cbc_pkg::cbc_view_t      view;
    cbc_pkg::cbc_ram_state_t ram_state;
    logic [7:0]              read_data;
    logic                    clr_busy;
    logic                    advance;
    logic                    accept;

    // handshake control
    assign advance       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !clr_busy && (!s1_valid_reg || advance);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kind            <= cbc_pkg::KIND_NONE;
            cfg_reg.rom_bank_mask   <= 9'd1;
            cfg_reg.ram_bank_mask   <= 4'd0;
            cfg_reg.ram_offset_mask <= 13'd0;
            cfg_reg.ram_present     <= 1'b0;
            cfg_reg.rom_banking_on  <= 1'b0;
            cfg_reg.ram_unbanked    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cbc_pkg::CFG_KIND:        cfg_reg.kind            <= cfg_data[2:0];
                cbc_pkg::CFG_ROM_MASK:    cfg_reg.rom_bank_mask   <= cfg_data[8:0];
                cbc_pkg::CFG_RAM_MASK:    cfg_reg.ram_bank_mask   <= cfg_data[3:0];
                cbc_pkg::CFG_OFFSET_MASK: cfg_reg.ram_offset_mask <= cfg_data;
                cbc_pkg::CFG_RAM_PRESENT: cfg_reg.ram_present     <= cfg_data[0];
                cbc_pkg::CFG_ROM_BANKING: cfg_reg.rom_banking_on  <= cfg_data[0];
                cbc_pkg::CFG_UNBANKED:    cfg_reg.ram_unbanked    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.req_type <= s_axis_tuser;
            req_reg.addr     <= s_axis_tdata[15:0];
            req_reg.data     <= s_axis_tdata[23:16];
        end
    end

    cbc_mapper u_mapper (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req       (req_reg),
        .commit    (advance),
        .ram_state (ram_state),
        .view      (view)
    );

    cbc_ram u_ram (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req       (req_reg),
        .ram_state (ram_state),
        .step      (advance),
        .read_data (read_data),
        .clr_busy  (clr_busy)
    );

    // result stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            view_reg <= view;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, view_reg.ram_en, view_reg.ram_bank,
                            view_reg.rom_upper, view_reg.rom_lower, read_data};

    // pipeline checks
    `CBC_ASSERT_NOW(a_no_accept_in_sweep, clr_busy, !s_axis_tready, "request taken during ram clear")
    `CBC_ASSERT_NOW(a_empty_in_sweep, clr_busy, !s1_valid_reg, "request in flight during ram clear")
    `CBC_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_reg, "advanced request produced no result")
    `CBC_ASSERT_NEXT(a_held_request_kept, s1_valid_reg && !advance, s1_valid_reg && $stable(req_reg), "held request lost or changed")

endmodule

// File: bench/cbc_bank_checker.sv
// result checker for the cartridge bank controller: mirrors banking registers and external ram
// depends on cbc_pkg; watches the request, result and config channels beside the block
`timescale 1ns / 1ps

module cbc_bank_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // bus_address[15:0], write_data[23:16]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // read_data, rom_bank_lower, rom_bank_upper,
                                        // ram_bank_now, ram_enabled_now, zero pad
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data,
    output int          mismatches,
    output int          outstanding
);

    import cbc_pkg::*;

    typedef struct packed {
        logic [7:0] read_data;
        cbc_view_t  view;
    } access_outcome_t;

    // mirrored configuration and banking state
    cbc_cfg_t   cfg_now;
    logic [8:0] rom_bank;
    logic [3:0] ram_bank;
    logic       ram_enable;
    logic       mbc1_mode;
    logic [5:0] outer_bank;
    logic [5:0] inner_bank;
    logic [5:0] outer_mask;
    logic [5:0] inner_mask;
    logic       mc_phase;
    logic       mc_locked;
    logic [6:0] base_bank;
    logic [6:0] switch_bank;
    logic [7:0] cart_ram [0:RAM_BYTES-1];

    access_outcome_t outcome_q [$];
    access_outcome_t due;
    access_outcome_t fresh;
    int              ram_i;

    // multicart lower and upper bank from outer and inner parts
    task automatic refresh_multicart;
        logic [5:0] outer_sel;
        outer_sel   = outer_bank & outer_mask;
        base_bank   = {outer_sel, 1'b0};
        switch_bank = {outer_sel, 1'b0} + {1'b0, inner_bank & inner_mask};
    endtask

    // one bus request: update the mirrored state and build the expected result
    task automatic apply_access(input logic [1:0] req, input logic [15:0] a,
                                input logic [7:0] v, output access_outcome_t res);
        logic [8:0]  bank;
        logic [16:0] idx;
        logic        ungated;
        logic        multi;
        logic [1:0]  region;
        bank    = '0;
        idx     = '0;
        region  = a[14:13];
        multi   = (cfg_now.kind == KIND_MULTI);
        ungated = cfg_now.ram_unbanked && (cfg_now.kind != KIND_MBC2);
        res.read_data = NO_DATA;
        if (req == REQ_REG && !a[15])
        begin
            case (cfg_now.kind)
                KIND_MBC1:
                begin
                    if (region == REGION_ENABLE)
                        ram_enable = (v[3:0] == ENABLE_KEY);
                    else if (region == REGION_ROM)
                    begin
                        if (cfg_now.rom_banking_on)
                        begin
                            bank = {rom_bank[8:5], v[4:0]};
                            if (bank[4:0] == 5'd0)
                                bank[0] = 1'b1;
                            rom_bank = bank & cfg_now.rom_bank_mask;
                        end
                    end
                    else if (region == REGION_RAM)
                    begin
                        if (mbc1_mode)
                        begin
                            if (cfg_now.ram_present)
                                ram_bank = {2'b00, v[1:0]} & cfg_now.ram_bank_mask;
                        end
                        else if (cfg_now.rom_banking_on)
                        begin
                            // upper bank bits replace bits 6:5 and clear 8:7
                            bank = {2'b00, v[1:0], rom_bank[4:0]};
                            if (bank[4:0] == 5'd0)
                                bank[0] = 1'b1;
                            rom_bank = bank & cfg_now.rom_bank_mask;
                        end
                    end
                    else
                        mbc1_mode = (v != 8'd0);
                end
                KIND_MBC2:
                begin
                    // address bit 8 splits enable and rom bank writes
                    if (region == REGION_ENABLE && !a[8])
                        ram_enable = (v[3:0] == ENABLE_KEY);
                    else if (region == REGION_ROM && a[8] && cfg_now.rom_banking_on)
                    begin
                        bank = {2'b00, v[6:0]};
                        if (bank == 9'd0)
                            bank = 9'd1;
                        rom_bank = bank & cfg_now.rom_bank_mask;
                    end
                end
                KIND_MBC3:
                begin
                    if (region == REGION_ENABLE)
                        ram_enable = (v[3:0] == ENABLE_KEY);
                    else if (region == REGION_ROM)
                    begin
                        if (cfg_now.rom_banking_on)
                        begin
                            bank = {2'b00, v[6:0]};
                            if (bank == 9'd0)
                                bank = 9'd1;
                            rom_bank = bank & cfg_now.rom_bank_mask;
                        end
                    end
                    // clock register selects and latch writes change nothing
                    else if (region == REGION_RAM && v[3:2] == 2'b00 && cfg_now.ram_present)
                        ram_bank = {2'b00, v[1:0]} & cfg_now.ram_bank_mask;
                end
                KIND_MBC5:
                begin
                    if (region == REGION_ENABLE)
                        ram_enable = (v[3:0] == ENABLE_KEY);
                    else if (region == REGION_ROM)
                    begin
                        if (cfg_now.rom_banking_on)
                        begin
                            if (!a[12])
                                rom_bank = {rom_bank[8], v} & cfg_now.rom_bank_mask;
                            else
                                rom_bank = {v[0], rom_bank[7:0]} & cfg_now.rom_bank_mask;
                        end
                    end
                    else if (region == REGION_RAM && cfg_now.ram_present)
                        ram_bank = v[3:0] & cfg_now.ram_bank_mask;
                end
                KIND_MULTI:
                begin
                    if (region == REGION_ROM)
                    begin
                        inner_bank = v[5:0];
                        if (inner_bank == 6'd0)
                            inner_bank = 6'd1;
                        refresh_multicart();
                    end
                    else if (region == REGION_MODE && !mc_locked)
                    begin
                        // alternating writes: outer bank, then masks and lock
                        if (!mc_phase)
                            outer_bank = v[5:0];
                        else
                        begin
                            inner_mask = ~{v[4:0], 1'b0};
                            outer_mask = {1'b1, v[4:0]};
                            mc_locked  = v[5];
                        end
                        refresh_multicart();
                        mc_phase = ~mc_phase;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if ((req == REQ_READ || req == REQ_WRITE) && cfg_now.ram_present)
        begin
            if (cfg_now.kind == KIND_MBC2)
            begin
                // nibble cells, upper half always reads set
                if (ram_enable)
                begin
                    idx = {8'd0, a[8:0]};
                    if (req == REQ_WRITE)
                        cart_ram[idx] = v | MBC2_HIGH;
                    else
                        res.read_data = cart_ram[idx] | MBC2_HIGH;
                end
            end
            else if (ungated || ram_enable)
            begin
                idx = {(ungated ? 4'd0 : ram_bank), a[12:0] & cfg_now.ram_offset_mask};
                if (req == REQ_WRITE)
                    cart_ram[idx] = v;
                else
                    res.read_data = cart_ram[idx];
            end
        end
        res.view.rom_lower = multi ? base_bank : 7'd0;
        res.view.rom_upper = multi ? {2'b00, switch_bank} : rom_bank;
        res.view.ram_bank  = ram_bank;
        res.view.ram_en    = cfg_now.ram_present && (ungated || ram_enable);
    endtask

    task check_field(input string what, input logic [15:0] want, input logic [15:0] got);
        if (want !== got)
        begin
            mismatches = mismatches + 1;
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
        end
    endtask

    // config writes, result compare, then the new request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_now.kind            = KIND_NONE;
            cfg_now.rom_bank_mask   = 9'd1;
            cfg_now.ram_bank_mask   = 4'd0;
            cfg_now.ram_offset_mask = 13'd0;
            cfg_now.ram_present     = 1'b0;
            cfg_now.rom_banking_on  = 1'b0;
            cfg_now.ram_unbanked    = 1'b0;
            rom_bank    = 9'd1;
            ram_bank    = 4'd0;
            ram_enable  = 1'b0;
            mbc1_mode   = 1'b0;
            outer_bank  = 6'd0;
            inner_bank  = 6'd1;
            outer_mask  = 6'h20;
            inner_mask  = 6'h3F;
            mc_phase    = 1'b0;
            mc_locked   = 1'b0;
            base_bank   = 7'd0;
            switch_bank = 7'd1;
            for (ram_i = 0; ram_i < RAM_BYTES; ram_i++)
                cart_ram[ram_i] = 8'd0;
            outcome_q.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_KIND:        cfg_now.kind            = cfg_data[2:0];
                    CFG_ROM_MASK:    cfg_now.rom_bank_mask   = cfg_data[8:0];
                    CFG_RAM_MASK:    cfg_now.ram_bank_mask   = cfg_data[3:0];
                    CFG_OFFSET_MASK: cfg_now.ram_offset_mask = cfg_data;
                    CFG_RAM_PRESENT: cfg_now.ram_present     = cfg_data[0];
                    CFG_ROM_BANKING: cfg_now.rom_banking_on  = cfg_data[0];
                    CFG_UNBANKED:    cfg_now.ram_unbanked    = cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (outcome_q.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    $display("%0t ns: result with no request waiting, expected none, got 0x%0h",
                             $time, m_axis_tdata);
                end
                else
                begin
                    due = outcome_q.pop_front();
                    check_field("read_data", {8'd0, due.read_data}, {8'd0, m_axis_tdata[7:0]});
                    check_field("rom_bank_lower", {9'd0, due.view.rom_lower},
                                {9'd0, m_axis_tdata[14:8]});
                    check_field("rom_bank_upper", {7'd0, due.view.rom_upper},
                                {7'd0, m_axis_tdata[23:15]});
                    check_field("ram_bank_now", {12'd0, due.view.ram_bank},
                                {12'd0, m_axis_tdata[27:24]});
                    check_field("ram_enabled_now", {15'd0, due.view.ram_en},
                                {15'd0, m_axis_tdata[28]});
                    check_field("pad", 16'd0, {13'd0, m_axis_tdata[31:29]});
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_access(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[23:16], fresh);
                outcome_q.push_back(fresh);
            end
            outstanding = outcome_q.size();
        end
    end

endmodule

// File: bench/tb_cartridge_bank_controller.sv
// regression top for the cartridge bank controller: clock, reset, requests, config and verdict
// depends on cbc_pkg, the block under test and cbc_bank_checker
`timescale 1ns / 1ps

module tb_cartridge_bank_controller;

    import cbc_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // bus_address[15:0], write_data[23:16]
    logic [1:0]  s_axis_tuser;   // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // read_data, rom_bank_lower, rom_bank_upper,
                                 // ram_bank_now, ram_enabled_now, zero pad
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [12:0] cfg_data;

    int          mismatches;
    int          outstanding;
    int          reqs_taken = 0;
    int          cfgs_taken = 0;
    logic        tx_gaps;
    logic        rx_gaps = 1'b1;
    logic        rx_hold_req = 1'b0;
    logic [12:0] hot_spots [8];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    cartridge_bank_controller DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    cbc_bank_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // handshake counters, read back at the falling edge
    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            reqs_taken <= reqs_taken + 1;
        if (cfg_valid && cfg_ready)
            cfgs_taken <= cfgs_taken + 1;
    end

    // result side: random stalls, one long hold on demand
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (300) @(negedge clk);
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (rx_gaps && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // run guard
    initial
    begin
        #4000000;
        $display("cartridge_bank_controller regression: fail");
        $finish;
    end

    // offer one request, return at the falling edge after it was taken
    task automatic push_request(input logic [1:0] req, input logic [15:0] addr,
                                input logic [7:0] data);
        int seen;
        if (tx_gaps && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        seen = reqs_taken;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {data, addr};
        s_axis_tuser  <= req;
        do @(negedge clk); while (reqs_taken == seen);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [12:0] val);
        int seen;
        seen = cfgs_taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge clk); while (cfgs_taken == seen);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_bank_config(input logic [2:0] kind, input logic [8:0] rom_mask,
                                   input logic [3:0] ram_mask, input logic [12:0] off_mask,
                                   input logic present, input logic banking,
                                   input logic unbanked);
        write_reg(CFG_KIND, {10'd0, kind});
        write_reg(CFG_ROM_MASK, {4'd0, rom_mask});
        write_reg(CFG_RAM_MASK, {9'd0, ram_mask});
        write_reg(CFG_OFFSET_MASK, off_mask);
        write_reg(CFG_RAM_PRESENT, {12'd0, present});
        write_reg(CFG_ROM_BANKING, {12'd0, banking});
        write_reg(CFG_UNBANKED, {12'd0, unbanked});
    endtask

    // stop offering and wait until every result is back
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        int          p;
        int          n;
        int          k;
        logic [31:0] rnd;
        logic [1:0]  req;
        logic [1:0]  region;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [12:0] offs;
        logic [2:0]  kind;
        logic [8:0]  rmask;
        logic [3:0]  bmask;
        logic [12:0] omask;
        logic        pres;
        logic        bank_on;
        logic        unb;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 24'd0;
        s_axis_tuser  = REQ_REG;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_KIND;
        cfg_data      = 13'd0;
        tx_gaps       = 1'b1;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // mbc1: unknown request, high register address, enable, banking and mode
        set_bank_config(KIND_MBC1, 9'h1FF, 4'hF, 13'h1FFF, 1'b1, 1'b1, 1'b0);
        push_request(2'd3, 16'hFFFF, 8'hFF);
        push_request(REQ_REG, 16'h8000, 8'h0A);
        push_request(REQ_READ, 16'hA000, 8'h00);
        push_request(REQ_REG, 16'h0000, 8'h0A);
        push_request(REQ_WRITE, 16'hBFFF, 8'hFF);
        push_request(REQ_READ, 16'hBFFF, 8'h00);
        push_request(REQ_REG, 16'h2000, 8'h00);
        push_request(REQ_REG, 16'h4000, 8'h03);
        push_request(REQ_REG, 16'h6000, 8'h01);
        push_request(REQ_REG, 16'h5FFF, 8'h03);
        push_request(REQ_WRITE, 16'hA000, 8'h5A);
        push_request(REQ_READ, 16'hA000, 8'h00);
        drain();

        // mbc3: clock register selects and latch writes are ignored
        set_bank_config(KIND_MBC3, 9'h1FF, 4'hF, 13'h1FFF, 1'b1, 1'b1, 1'b0);
        push_request(REQ_REG, 16'h1FFF, 8'h0A);
        push_request(REQ_REG, 16'h4000, 8'h08);
        push_request(REQ_REG, 16'h6000, 8'h01);
        push_request(REQ_REG, 16'h3FFF, 8'h80);
        push_request(REQ_READ, 16'hB000, 8'h00);
        drain();

        // multicart: enable never takes, outer and inner bank at their top values, inner bank zero, then a mask write
        set_bank_config(KIND_MULTI, 9'h1FF, 4'hF, 13'h1FFF, 1'b1, 1'b1, 1'b0);
        push_request(REQ_REG, 16'h0000, 8'h0A);
        push_request(REQ_READ, 16'hA000, 8'h00);
        push_request(REQ_REG, 16'h6000, 8'h3F);
        push_request(REQ_REG, 16'h2000, 8'h3F);
        push_request(REQ_REG, 16'h2000, 8'h00);
        push_request(REQ_REG, 16'h7FFF, 8'h15);
        push_request(REQ_READ, 16'hA000, 8'h00);
        drain();

        // random phases, one controller setting each
        for (p = 0; p < 12; p++)
        begin
            if (p < 6)
                rnd = (p + 1) % 6;
            else
                rnd = $urandom_range(0, 5);
            kind    = rnd[2:0];
            rnd     = $urandom;
            rmask   = rnd[8:0];
            bmask   = rnd[12:9];
            omask   = rnd[25:13];
            pres    = ($urandom_range(0, 3) != 0);
            bank_on = ($urandom_range(0, 3) != 0);
            unb     = ($urandom_range(0, 3) == 0);
            if (p == 0 || p == 6)
            begin
                rmask   = '1;
                bmask   = '1;
                omask   = '1;
                pres    = 1'b1;
                bank_on = 1'b1;
                unb     = (p == 6);
            end
            else if (p == 1)
            begin
                rmask   = '0;
                bmask   = '0;
                omask   = '0;
                pres    = 1'b1;
                bank_on = 1'b1;
                unb     = 1'b0;
            end
            set_bank_config(kind, rmask, bmask, omask, pres, bank_on, unb);
            for (k = 0; k < 8; k++)
            begin
                rnd = $urandom;
                hot_spots[k] = rnd[12:0];
            end
            // last phases run with no idling on either side
            tx_gaps = (p < 10) && ($urandom_range(0, 3) != 0);
            rx_gaps = (p < 10) && ($urandom_range(0, 3) != 0);
            if (p == 3)
                rx_hold_req = 1'b1;
            for (n = 0; n < 92; n++)
            begin
                if (p == 5 && n == 46)
                begin
                    s_axis_tvalid <= 1'b0;
                    while (outstanding != 0) @(negedge clk);
                    @(negedge clk);
                end
                rnd = $urandom;
                if (rnd[31:25] < 7'd13)
                begin
                    // noise: any type, any address
                    req  = rnd[1:0];
                    addr = rnd[17:2];
                    data = rnd[25:18];
                end
                else if (rnd[31:25] < 7'd48)
                begin
                    // banking register write, mostly meaningful values
                    req    = REQ_REG;
                    region = rnd[1:0];
                    addr   = {1'b0, region, rnd[14:2]};
                    if (region == REGION_ENABLE && rnd[15])
                        data = {rnd[19:16], ENABLE_KEY};
                    else if (rnd[16])
                        data = {5'd0, rnd[22:20]};
                    else
                        data = rnd[24:17];
                end
                else
                begin
                    // external ram access around a few hot offsets
                    req  = rnd[0] ? REQ_WRITE : REQ_READ;
                    offs = (rnd[3:1] == 3'd0) ? rnd[16:4] : hot_spots[rnd[19:17]];
                    addr = {3'b101, offs};
                    data = rnd[27:20];
                end
                push_request(req, addr, data);
            end
            drain();
        end

        s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("cartridge_bank_controller regression: pass");
        else
            $display("cartridge_bank_controller regression: fail");
        $finish;
    end

endmodule
